@@ rtl/core/ptb_pkg.sv @@
`default_nettype none

package ptb_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ID_WIDTH    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int RES_WIDTH   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      CMD_TICK        = 3'd0,
      CMD_INIT        = 3'd1,
      CMD_START       = 3'd2,
      CMD_STOP        = 3'd3,
      CMD_DISABLE_ALL = 3'd4
   } cmd_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                   hit;
      logic                   dis_all;
      cmd_type                op;
      logic [ID_WIDTH-1:0]    id;
      logic [COUNT_WIDTH-1:0] period;
      logic                   once;
      logic                   kind;
      logic                   tgt;
      logic                   clr;
   } ctl_type;

   typedef struct packed {
      logic emit;
      logic kind;
   } cell_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/ptb_cell.sv @@
`default_nettype none

module ptb_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ptb_pkg::ID_WIDTH-1:0]  cell_id,
   input  wire ptb_pkg::ctl_type              ctl,
   input  wire logic                          tok_prev,
   input  wire logic                          step_en,
   input  wire logic                          later_in,
   output logic                               tok,
   output ptb_pkg::cell_stat_type             stat,
   output logic                               later_out
);

   logic [ptb_pkg::COUNT_WIDTH-1:0] per_ff, per_in;
   logic [ptb_pkg::COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [ptb_pkg::COUNT_WIDTH-1:0] cnt_inc;
   logic once_ff, once_in;
   logic en_ff, en_in;
   logic kind_ff, kind_in;
   logic tgt_ff, tgt_in;
   logic tok_ff, tok_in;
   logic fire;
   logic sel;

   assign cnt_inc = cnt_ff + 1'b1;
   assign fire    = en_ff && (cnt_inc >= per_ff);
   assign sel     = ctl.hit && (ctl.id == cell_id);

   assign tok       = tok_ff;
   assign stat.emit = fire && tgt_ff;
   assign stat.kind = kind_ff;
   assign later_out = stat.emit || later_in;

   // hand the scan token on only when the whole chain may advance
   assign tok_in = step_en ? tok_prev : tok_ff;

   always_comb begin
      per_in  = per_ff;
      cnt_in  = cnt_ff;
      once_in = once_ff;
      en_in   = en_ff;
      kind_in = kind_ff;
      tgt_in  = tgt_ff;
      if (ctl.dis_all) begin
         en_in = 1'b0;
      end else if (sel) begin
         case (ctl.op)
            ptb_pkg::CMD_INIT: begin
               per_in  = ctl.period;
               cnt_in  = '0;
               once_in = ctl.once;
               en_in   = 1'b0;
               kind_in = ctl.kind;
               tgt_in  = ctl.tgt;
            end
            ptb_pkg::CMD_START: begin
               if (ctl.clr) cnt_in = '0;
               en_in = 1'b1;
            end
            ptb_pkg::CMD_STOP: begin
               if (ctl.clr) cnt_in = '0;
               en_in = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (tok_ff && step_en && en_ff) begin
         cnt_in = fire ? '0 : cnt_inc;
         if (fire && once_ff) en_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         per_ff  <= '0;
         cnt_ff  <= '0;
         once_ff <= 1'b0;
         en_ff   <= 1'b0;
         kind_ff <= 1'b0;
         tgt_ff  <= 1'b0;
         tok_ff  <= 1'b0;
      end else begin
         per_ff  <= per_in;
         cnt_ff  <= cnt_in;
         once_ff <= once_in;
         en_ff   <= en_in;
         kind_ff <= kind_in;
         tgt_ff  <= tgt_in;
         tok_ff  <= tok_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/periodic_timer_bank.sv @@
// Init, start, stop and disable-all take effect in the cycle after acceptance; the next
// word is taken in the following cycle.
// A tick passes a token down the row of timer cells, one cell per cycle while no expiry
// waits on a held result word; the bank takes no new word until the token has left the
// last cell. A result word is registered when the token is at an expiring cell with a
// target and the result register is free.
// Synchronous reset clears every timer to zero and leaves the bank idle and ready.
`default_nettype none

module periodic_timer_bank (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_timer_id,
   input  wire logic [15:0] req_period,
   input  wire logic        req_run_once,
   input  wire logic        req_notify_kind,
   input  wire logic        req_has_target,
   input  wire logic        req_clear_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_expired_id,
   output logic             rsp_expired_kind,
   output logic             rsp_last
);

   localparam int N = ptb_pkg::NUM_TIMERS;

   ptb_pkg::ctl_type ctl;
   ptb_pkg::cmd_type cmd;

   logic [N:0]   tok_src;
   logic [N:0]   later_vec;
   logic [N-1:0] tok_vec, emit_vec, kind_vec;
   ptb_pkg::cell_stat_type stat_vec [N];

   logic accept, is_tick, busy, in_range;
   logic sel_emit, sel_kind, sel_later;
   logic out_free, room, send, step_en;

   logic [ptb_pkg::ID_WIDTH-1:0]  idx_ff, idx_in;
   logic [ptb_pkg::RES_WIDTH-1:0] res_cnt_ff, res_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_id_ff;
   logic       rsp_kind_ff, rsp_last_ff;

   assign busy      = |tok_vec;
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign cmd       = ptb_pkg::cmd_type'(req_cmd);
   assign in_range  = req_timer_id < 8'(N);

   always_comb begin
      ctl         = '0;
      ctl.op      = cmd;
      ctl.id      = ptb_pkg::ID_WIDTH'(req_timer_id);
      ctl.period  = ptb_pkg::COUNT_WIDTH'(req_period);
      ctl.once    = req_run_once;
      ctl.kind    = req_notify_kind;
      ctl.tgt     = req_has_target;
      ctl.clr     = req_clear_count;
      is_tick     = 1'b0;
      case (cmd)
         ptb_pkg::CMD_TICK:        is_tick     = accept;
         ptb_pkg::CMD_DISABLE_ALL: ctl.dis_all = accept;
         ptb_pkg::CMD_INIT,
         ptb_pkg::CMD_START,
         ptb_pkg::CMD_STOP:        ctl.hit     = accept && in_range;
         default: begin
         end
      endcase
   end

   assign tok_src[0]   = is_tick;
   assign later_vec[N] = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      ptb_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (ptb_pkg::ID_WIDTH'(i)),
         .ctl       (ctl),
         .tok_prev  (tok_src[i]),
         .step_en   (step_en),
         .later_in  (later_vec[i+1]),
         .tok       (tok_src[i+1]),
         .stat      (stat_vec[i]),
         .later_out (later_vec[i])
      );
      assign tok_vec[i]  = tok_src[i+1];
      assign emit_vec[i] = stat_vec[i].emit;
      assign kind_vec[i] = stat_vec[i].kind;
   end

   assign sel_emit  = |(tok_vec & emit_vec);
   assign sel_kind  = |(tok_vec & kind_vec);
   assign sel_later = |(tok_vec & later_vec[N:1]);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign room     = res_cnt_ff < ptb_pkg::RES_WIDTH'(ptb_pkg::MAX_RESULTS);
   assign send     = sel_emit && room;
   // hold the token while an expiry waits for the word register
   assign step_en  = !send || out_free;

   assign rsp_valid_in = out_free ? send : rsp_valid_ff;
   assign res_cnt_in   = is_tick ? '0 :
                         (send && out_free) ? res_cnt_ff + 1'b1 : res_cnt_ff;
   assign idx_in       = is_tick ? '0 :
                         (busy && step_en) ? ptb_pkg::ID_WIDTH'(idx_ff + 1'b1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         res_cnt_ff   <= '0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         res_cnt_ff   <= res_cnt_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (send && out_free) begin
         rsp_id_ff   <= 4'(idx_ff);
         rsp_kind_ff <= sel_kind;
         rsp_last_ff <= !sel_later ||
                        (res_cnt_ff == ptb_pkg::RES_WIDTH'(ptb_pkg::MAX_RESULTS - 1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_id   = rsp_id_ff;
   assign rsp_expired_kind = rsp_kind_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/core/ptb_checker.sv @@
`default_nettype none

module ptb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [2:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_expired_id,
   input wire logic       rsp_expired_kind,
   input wire logic       rsp_last
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expired_id) &&
      $stable(rsp_expired_kind) && $stable(rsp_last))
      else $error("stalled result word changed");

   // a tick occupies the bank for its scan
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == ptb_pkg::CMD_TICK |=> !req_ready)
      else $error("bank ready right after taking a tick");

   // other commands raise no result
   a_cmd_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != ptb_pkg::CMD_TICK && !rsp_valid |=> !rsp_valid)
      else $error("result raised by a non-tick command");

   // a result that is not last means the scan is still running
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("scan ended before the last result");

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_expired_id   (rsp_expired_id),
   .rsp_expired_kind (rsp_expired_kind),
   .rsp_last         (rsp_last)
);

`default_nettype wire

@@ bench/ptb_expiry_checker.sv @@
`default_nettype none

module ptb_expiry_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_timer_id,
   input  wire logic [15:0] req_period,
   input  wire logic        req_run_once,
   input  wire logic        req_notify_kind,
   input  wire logic        req_has_target,
   input  wire logic        req_clear_count,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [3:0]  rsp_expired_id,
   input  wire logic        rsp_expired_kind,
   input  wire logic        rsp_last,
   output int               mismatches,
   output int               pending,
   output int               words_in,
   output int               ticks_in,
   output int               expiries_due,
   output int               expiries_seen
);

   typedef struct packed {
      logic [3:0] id;
      logic       kind;
      logic       last;
   } expiry_word_type;

   logic [ptb_pkg::COUNT_WIDTH-1:0] period_of [ptb_pkg::NUM_TIMERS];
   logic [ptb_pkg::COUNT_WIDTH-1:0] count_of  [ptb_pkg::NUM_TIMERS];
   logic                            one_shot  [ptb_pkg::NUM_TIMERS];
   logic                            running   [ptb_pkg::NUM_TIMERS];
   logic                            kind_of   [ptb_pkg::NUM_TIMERS];
   logic                            notify    [ptb_pkg::NUM_TIMERS];

   expiry_word_type expiry_q [$];

   task automatic clear_bank();
      for (int t = 0; t < ptb_pkg::NUM_TIMERS; t++) begin
         period_of[t] = '0;
         count_of[t]  = '0;
         one_shot[t]  = 1'b0;
         running[t]   = 1'b0;
         kind_of[t]   = 1'b0;
         notify[t]    = 1'b0;
      end
   endtask

   // advance every running timer and queue the expiries in ascending id order
   task automatic run_tick();
      expiry_word_type                 tick_q [$];
      expiry_word_type                 w;
      logic [ptb_pkg::COUNT_WIDTH-1:0] nxt;
      for (int t = 0; t < ptb_pkg::NUM_TIMERS; t++) begin
         if (running[t]) begin
            nxt = count_of[t] + 1'b1;
            if (nxt >= period_of[t]) begin
               nxt = '0;
               if (one_shot[t])
                  running[t] = 1'b0;
               if (notify[t] && tick_q.size() < ptb_pkg::MAX_RESULTS) begin
                  w.id   = 4'(t);
                  w.kind = kind_of[t];
                  w.last = 1'b0;
                  tick_q.push_back(w);
               end
            end
            count_of[t] = nxt;
         end
      end
      if (tick_q.size() > 0) begin
         w = tick_q.pop_back();
         w.last = 1'b1;
         tick_q.push_back(w);
      end
      foreach (tick_q[i])
         expiry_q.push_back(tick_q[i]);
      expiries_due += tick_q.size();
   endtask

   task automatic take_command(input logic [2:0] op, input logic [7:0] id,
                               input logic [15:0] per, input logic once,
                               input logic kind, input logic tgt, input logic clr);
      logic [ptb_pkg::ID_WIDTH-1:0] slot;
      slot = ptb_pkg::ID_WIDTH'(id);
      case (op)
         ptb_pkg::CMD_TICK: begin
            ticks_in++;
            run_tick();
         end
         ptb_pkg::CMD_DISABLE_ALL: begin
            for (int t = 0; t < ptb_pkg::NUM_TIMERS; t++)
               running[t] = 1'b0;
         end
         ptb_pkg::CMD_INIT: begin
            if (id < ptb_pkg::NUM_TIMERS) begin
               period_of[slot] = per[ptb_pkg::COUNT_WIDTH-1:0];
               count_of[slot]  = '0;
               one_shot[slot]  = once;
               running[slot]   = 1'b0;
               kind_of[slot]   = kind;
               notify[slot]    = tgt;
            end
         end
         ptb_pkg::CMD_START, ptb_pkg::CMD_STOP: begin
            if (id < ptb_pkg::NUM_TIMERS) begin
               if (clr)
                  count_of[slot] = '0;
               running[slot] = (op == ptb_pkg::CMD_START);
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_fault(input string why, input expiry_word_type want,
                             input expiry_word_type got, input bit none_due);
      mismatches++;
      if (mismatches <= 10) begin
         if (none_due)
            $display("[%0t] %s: got id=%0d kind=%0d last=%0d, expected none",
                     $realtime, why, got.id, got.kind, got.last);
         else
            $display("[%0t] %s: got id=%0d kind=%0d last=%0d, expected id=%0d kind=%0d last=%0d",
                     $realtime, why, got.id, got.kind, got.last,
                     want.id, want.kind, want.last);
      end
   endtask

   always @(posedge clock) begin
      expiry_word_type got;
      expiry_word_type want;
      if (reset) begin
         clear_bank();
         expiry_q.delete();
         mismatches    = 0;
         words_in      = 0;
         ticks_in      = 0;
         expiries_due  = 0;
         expiries_seen = 0;
      end else begin
         if (req_valid && req_ready) begin
            words_in++;
            take_command(req_cmd, req_timer_id, req_period, req_run_once,
                         req_notify_kind, req_has_target, req_clear_count);
         end
         if (rsp_valid && rsp_ready) begin
            expiries_seen++;
            got = {rsp_expired_id, rsp_expired_kind, rsp_last};
            if (expiry_q.size() == 0) begin
               note_fault("expiry word with none due", got, got, 1'b1);
            end else begin
               want = expiry_q.pop_front();
               if (got.id != want.id)
                  note_fault("expired_id differs", want, got, 1'b0);
               else if (got.kind != want.kind)
                  note_fault("expired_kind differs", want, got, 1'b0);
               else if (got.last != want.last)
                  note_fault("last differs", want, got, 1'b0);
            end
         end
      end
      pending = expiry_q.size();
   end

endmodule

`default_nettype wire

@@ bench/periodic_timer_bank_tb.sv @@
`default_nettype none

module periodic_timer_bank_tb;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam int TOTAL_WORDS  = 180;
   localparam int DRAIN_CYCLES = 2 * ptb_pkg::NUM_TIMERS + 8;
   localparam int RUN_LIMIT    = 5_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_cmd;
   logic [7:0]  req_timer_id;
   logic [15:0] req_period;
   logic        req_run_once;
   logic        req_notify_kind;
   logic        req_has_target;
   logic        req_clear_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_expired_id;
   logic        rsp_expired_kind;
   logic        rsp_last;

   int mismatches;
   int pending;
   int words_in;
   int ticks_in;
   int expiries_due;
   int expiries_seen;
   bit req_calm;

   periodic_timer_bank dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .req_run_once     (req_run_once),
      .req_notify_kind  (req_notify_kind),
      .req_has_target   (req_has_target),
      .req_clear_count  (req_clear_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_expired_id   (rsp_expired_id),
      .rsp_expired_kind (rsp_expired_kind),
      .rsp_last         (rsp_last)
   );

   ptb_expiry_checker expiry_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_timer_id     (req_timer_id),
      .req_period       (req_period),
      .req_run_once     (req_run_once),
      .req_notify_kind  (req_notify_kind),
      .req_has_target   (req_has_target),
      .req_clear_count  (req_clear_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_expired_id   (rsp_expired_id),
      .rsp_expired_kind (rsp_expired_kind),
      .rsp_last         (rsp_last),
      .mismatches       (mismatches),
      .pending          (pending),
      .words_in         (words_in),
      .ticks_in         (ticks_in),
      .expiries_due     (expiries_due),
      .expiries_seen    (expiries_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // call at a falling edge; returns at the falling edge after acceptance with valid still high
   task automatic send_word(input logic [2:0] cmd, input logic [7:0] id,
                            input logic [15:0] per, input logic once, input logic kind,
                            input logic tgt, input logic clr);
      int gap;
      if ($urandom_range(0, 19) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         = cmd;
      req_timer_id    = id;
      req_period      = per;
      req_run_once    = once;
      req_notify_kind = kind;
      req_has_target  = tgt;
      req_clear_count = clr;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic program_timer(input logic [7:0] id, input logic [15:0] per,
                                input logic once, input logic kind, input logic tgt,
                                input bit go);
      send_word(ptb_pkg::CMD_INIT, id, per, once, kind, tgt, 1'(($urandom)));
      if (go)
         send_word(ptb_pkg::CMD_START, id, 16'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   // mostly short periods so that expiries come often, now and then any value
   function automatic logic [15:0] draw_period();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return 16'($urandom_range(0, 3));
      else if (pick < 9)
         return 16'($urandom_range(4, 20));
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      int   stall;
      bit   calm;
      calm      = 1'b0;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0)
            calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int         pick;
      logic [2:0] op;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = ptb_pkg::CMD_TICK;
      req_timer_id    = '0;
      req_period      = '0;
      req_run_once    = 1'b0;
      req_notify_kind = 1'b0;
      req_has_target  = 1'b0;
      req_clear_count = 1'b0;
      req_calm        = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tick, zero period, long period, no target, dropped ids, spare codes
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      program_timer(8'd0, 16'd0, 1'b0, 1'b1, 1'b1, 1'b1);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_INIT, 8'd15, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0);
      send_word(ptb_pkg::CMD_START, 8'd15, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      program_timer(8'd7, 16'd1, 1'b1, 1'b0, 1'b0, 1'b1);
      send_word(ptb_pkg::CMD_INIT, 8'(ptb_pkg::NUM_TIMERS), 16'd0, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(ptb_pkg::CMD_START, 8'd255, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      send_word(ptb_pkg::CMD_STOP, 8'd128, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_TICK, 8'd255, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         send_word(3'(c), 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
      send_word(ptb_pkg::CMD_STOP, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_START, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_DISABLE_ALL, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      program_timer(8'd3, 16'd2, 1'b0, 1'b1, 1'b1, 1'b1);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);

      // fill the whole bank with zero periods so one tick expires every timer
      for (int t = 0; t < ptb_pkg::NUM_TIMERS; t++) begin
         program_timer(8'(t), 16'd0, 1'($urandom), 1'($urandom), 1'b1, 1'b1);
      end
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_TICK, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_word(ptb_pkg::CMD_DISABLE_ALL, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);

      while (words_in < TOTAL_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            send_word(ptb_pkg::CMD_TICK, 8'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 62) begin
            program_timer(8'($urandom_range(0, ptb_pkg::NUM_TIMERS - 1)), draw_period(),
                          1'($urandom), 1'($urandom), ($urandom_range(0, 3) != 0),
                          ($urandom_range(0, 4) != 0));
         end else if (pick < 74) begin
            op = ($urandom_range(0, 2) != 0) ? ptb_pkg::CMD_START : ptb_pkg::CMD_STOP;
            send_word(op, 8'($urandom_range(0, ptb_pkg::NUM_TIMERS - 1)), 16'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 77) begin
            send_word(ptb_pkg::CMD_DISABLE_ALL, 8'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            // ids past the bank: drop without effect
            op = 3'($urandom_range(ptb_pkg::CMD_INIT, ptb_pkg::CMD_STOP));
            send_word(op, 8'($urandom_range(ptb_pkg::NUM_TIMERS, 255)), 16'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            send_word(3'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), 1'($urandom));
         end
      end
      req_valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d words with %0d ticks; checked %0d of %0d predicted expiry words.",
               words_in, ticks_in, expiries_seen, expiries_due);
      $display("Mismatches: %0d, expiry words still owed: %0d.", mismatches, pending);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
